// File: rtl/core/spcq_pkg.sv
package spcq_pkg;

   // fixed widths of the stream fields
   localparam int PRIO_W     = 2;
   localparam int SLOT_OUT_W = 4;
   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 192;

   // decoupling queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      ST_ACCEPTED   = 2'd0,
      ST_REJECTED   = 2'd1,
      ST_DISPATCHED = 2'd2,
      ST_EMPTY      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_ENQ,
      KIND_ENQ_BAD,
      KIND_DISPATCH
   } item_kind_type;

   typedef enum logic [0:0] {
      BK_IDLE,
      BK_DRAIN
   } back_state_type;

   typedef struct packed {
      logic [63:0] command_word;
      logic [15:0] cmd_tag;
      logic [63:0] fault_addr;
      logic [31:0] requester;
   } entry_type;

   typedef struct packed {
      item_kind_type     kind;
      logic [PRIO_W-1:0] prio;
      entry_type         entry;
   } item_type;

   typedef struct packed {
      status_type            status;
      entry_type             entry;
      logic [PRIO_W-1:0]     prio;
      logic [SLOT_OUT_W-1:0] sq_slot;
      logic [SLOT_OUT_W-1:0] doorbell_tail;
      logic                  last;
   } result_type;

endpackage

// File: rtl/core/spcq_front.sv
module spcq_front
   import spcq_pkg::*;
#(
   parameter int NUM_PRIORITIES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [PRIO_W-1:0] req_prio,
   input  entry_type         req_entry,
   output logic              out_valid,
   input  logic              out_ready,
   output item_type          out_item
);

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_item_ff, hold_item_in;
   item_type classified;

   always_comb begin
      classified.prio  = req_prio;
      classified.entry = req_entry;
      if (req_cmd) begin
         classified.kind = KIND_DISPATCH;
      end else if ({2'b00, req_prio} >= 4'(NUM_PRIORITIES)) begin
         classified.kind = KIND_ENQ_BAD;
      end else begin
         classified.kind = KIND_ENQ;
      end
   end

   assign req_ready = !hold_valid_ff || out_ready;

   always_comb begin
      hold_valid_in = req_ready ? req_valid : hold_valid_ff;
      hold_item_in  = (req_valid && req_ready) ? classified : hold_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_item_ff <= hold_item_in;
   end

   assign out_valid = hold_valid_ff;
   assign out_item  = hold_item_ff;

endmodule

// File: rtl/core/spcq_fifo.sv
module spcq_fifo
   import spcq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type              slots_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]   fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign push_ready = (fill_ff != (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = slots_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/spcq_back.sv
module spcq_back
   import spcq_pkg::*;
#(
   parameter int QUEUE_DEPTH    = 16,
   parameter int NUM_PRIORITIES = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   localparam int SLOTS  = QUEUE_DEPTH * NUM_PRIORITIES;
   localparam int LVL_W  = $clog2(NUM_PRIORITIES);
   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int TOT_W  = $clog2(SLOTS + 1);
   localparam int ADDR_W = $clog2(SLOTS);

   back_state_type state_ff, state_in;

   logic [SLOT_W-1:0] head_ff [NUM_PRIORITIES];
   logic [SLOT_W-1:0] head_in [NUM_PRIORITIES];
   logic [SLOT_W-1:0] tail_ff [NUM_PRIORITIES];
   logic [SLOT_W-1:0] tail_in [NUM_PRIORITIES];
   logic [CNT_W-1:0]  count_ff [NUM_PRIORITIES];
   logic [CNT_W-1:0]  count_in [NUM_PRIORITIES];
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [SLOT_W-1:0] submit_tail_ff, submit_tail_in;

   // entry store, one ring of QUEUE_DEPTH rows per level
   entry_type entry_mem [SLOTS];
   entry_type entry_rd_ff;

   // read stage between the entry store and the output register
   logic              stg_valid_ff, stg_valid_in;
   logic [LVL_W-1:0]  stg_lvl_ff, stg_lvl_in;
   logic [SLOT_W-1:0] stg_slot_ff, stg_slot_in;
   logic [SLOT_W-1:0] stg_db_ff, stg_db_in;
   logic              stg_last_ff, stg_last_in;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff, rsp_result_in;

   logic [LVL_W-1:0]  enq_lvl, drain_lvl;
   logic              enq_full, out_free, take;
   logic              enq_ok, emit_direct, start_drain, issue, stage_emit;
   status_type        direct_status;
   logic [SLOT_W-1:0] submit_next;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign enq_lvl  = LVL_W'(in_item.prio);
   assign enq_full = (count_ff[enq_lvl] == CNT_W'(QUEUE_DEPTH));

   // lowest nonempty level goes first
   always_comb begin
      drain_lvl = '0;
      for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            drain_lvl = LVL_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (start_drain) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if ((!stg_valid_ff || out_free) && total_ff == TOT_W'(1)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      take          = 1'b0;
      enq_ok        = 1'b0;
      emit_direct   = 1'b0;
      start_drain   = 1'b0;
      issue         = 1'b0;
      direct_status = ST_ACCEPTED;
      case (state_ff)
         BK_IDLE: begin
            take = in_valid && out_free && !stg_valid_ff;
            case (in_item.kind)
               KIND_ENQ: begin
                  enq_ok        = take && !enq_full;
                  emit_direct   = take;
                  direct_status = enq_full ? ST_REJECTED : ST_ACCEPTED;
               end
               KIND_DISPATCH: begin
                  start_drain   = take && (total_ff != '0);
                  emit_direct   = take && (total_ff == '0);
                  direct_status = ST_EMPTY;
               end
               default: begin
                  emit_direct   = take;
                  direct_status = ST_REJECTED;
               end
            endcase
         end
         BK_DRAIN: begin
            issue = !stg_valid_ff || out_free;
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   assign in_ready   = take;
   assign stage_emit = stg_valid_ff && out_free;

   assign submit_next = (submit_tail_ff == SLOT_W'(QUEUE_DEPTH - 1)) ?
                        '0 : submit_tail_ff + 1'b1;
   assign wr_addr = ADDR_W'(enq_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_ff[enq_lvl]);
   assign rd_addr = ADDR_W'(drain_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[drain_lvl]);

   // ring pointers and counts
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      submit_tail_in = submit_tail_ff;
      if (enq_ok) begin
         tail_in[enq_lvl]  = (tail_ff[enq_lvl] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                             '0 : tail_ff[enq_lvl] + 1'b1;
         count_in[enq_lvl] = count_ff[enq_lvl] + 1'b1;
         total_in          = total_ff + 1'b1;
      end
      if (issue) begin
         head_in[drain_lvl]  = (head_ff[drain_lvl] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                               '0 : head_ff[drain_lvl] + 1'b1;
         count_in[drain_lvl] = count_ff[drain_lvl] - 1'b1;
         total_in            = total_ff - 1'b1;
         submit_tail_in      = submit_next;
      end
   end

   // read stage
   always_comb begin
      stg_valid_in = issue ? 1'b1 : (stage_emit ? 1'b0 : stg_valid_ff);
      stg_lvl_in   = issue ? drain_lvl : stg_lvl_ff;
      stg_slot_in  = issue ? submit_tail_ff : stg_slot_ff;
      stg_db_in    = issue ? submit_next : stg_db_ff;
      stg_last_in  = issue ? (total_ff == TOT_W'(1)) : stg_last_ff;
   end

   // output register
   always_comb begin
      rsp_valid_in  = (stage_emit || emit_direct) ? 1'b1 :
                      (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_result_in = rsp_result_ff;
      if (stage_emit) begin
         rsp_result_in.status        = ST_DISPATCHED;
         rsp_result_in.entry         = entry_rd_ff;
         rsp_result_in.prio          = PRIO_W'(stg_lvl_ff);
         rsp_result_in.sq_slot       = SLOT_OUT_W'(stg_slot_ff);
         rsp_result_in.doorbell_tail = SLOT_OUT_W'(stg_db_ff);
         rsp_result_in.last          = stg_last_ff;
      end else if (emit_direct) begin
         rsp_result_in.status        = direct_status;
         rsp_result_in.entry         = '0;
         rsp_result_in.prio          = '0;
         rsp_result_in.sq_slot       = '0;
         rsp_result_in.doorbell_tail = '0;
         rsp_result_in.last          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_IDLE;
         total_ff       <= '0;
         submit_tail_ff <= '0;
         stg_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_PRIORITIES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         total_ff       <= total_in;
         submit_tail_ff <= submit_tail_in;
         stg_valid_ff   <= stg_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_lvl_ff    <= stg_lvl_in;
      stg_slot_ff   <= stg_slot_in;
      stg_db_ff     <= stg_db_in;
      stg_last_ff   <= stg_last_in;
      rsp_result_ff <= rsp_result_in;
   end

   always_ff @(posedge clock) begin
      if (enq_ok) begin
         entry_mem[wr_addr] <= in_item.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         entry_rd_ff <= entry_mem[rd_addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   a_drain_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DRAIN) |-> (total_ff != '0))
      else $error("drain running with all rings empty");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (issue && total_ff == TOT_W'(1)) |=> (total_ff == '0 && state_ff == BK_IDLE))
      else $error("final dispatched entry did not leave rings empty");

   a_enq_counts: assert property (@(posedge clock) disable iff (reset)
      enq_ok |=> (total_ff == $past(total_ff) + 1'b1))
      else $error("accepted item not counted");

   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      emit_direct |-> !stg_valid_ff)
      else $error("direct result overtook a dispatched entry");

endmodule

// File: rtl/core/strict_priority_command_queues_core.sv
// path: enqueue and empty-dispatch results pass the front register, input queue and output
// register; dispatched entries pass the read stage and output register. Throughput: one
// enqueue per cycle (single store write port) while rsp_tready is high and no drain runs;
// a drain emits one entry per cycle (single read port) while rsp_tready is high
// reset: synchronous, clears ring pointers, counts, submission tail, input queue and output;
// the entry store is not cleared and no clearing pass runs, items are taken right after reset
module strict_priority_command_queues_core
   import spcq_pkg::*;
#(
   parameter int QUEUE_DEPTH    = 16,
   parameter int NUM_PRIORITIES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // priority, command word, cmd tag, fault address, requester, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // command word, cmd tag, fault address, requester,
   // priority, sq slot, doorbell tail, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   entry_type  req_entry;
   logic       fr_valid, fr_ready;
   item_type   fr_item;
   logic       bk_valid, bk_ready;
   item_type   bk_item;
   result_type result;

   assign req_entry.command_word = req_tdata[65:2];
   assign req_entry.cmd_tag      = req_tdata[81:66];
   assign req_entry.fault_addr   = req_tdata[145:82];
   assign req_entry.requester    = req_tdata[177:146];

   spcq_front #(
      .NUM_PRIORITIES(NUM_PRIORITIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_prio  (req_tdata[1:0]),
      .req_entry (req_entry),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item)
   );

   spcq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_item  (fr_item),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_item   (bk_item)
   );

   spcq_back #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .NUM_PRIORITIES(NUM_PRIORITIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (bk_valid),
      .in_ready   (bk_ready),
      .in_item    (bk_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {6'b000000,
                       result.doorbell_tail,
                       result.sq_slot,
                       result.prio,
                       result.entry.requester,
                       result.entry.fault_addr,
                       result.entry.cmd_tag,
                       result.entry.command_word};
   assign rsp_tuser = result.status;
   assign rsp_tlast = result.last;

endmodule
